[rtl/core/circ_pkg.sv]
// ----------------------------------------------------------------------------
// circ_pkg
// Shared widths, command codes and the pixel job record of the circle
// outline generator.
// ----------------------------------------------------------------------------
package circ_pkg;

   localparam int COORD_BITS = 11;
   localparam int OFF_BITS   = COORD_BITS + 1;
   localparam int DEC_BITS   = COORD_BITS + 3;
   localparam int PIX_BITS   = COORD_BITS + 2;
   localparam int CALC_BITS  = COORD_BITS + 5;
   localparam int COLOR_BITS = 32;
   localparam int IDX_BITS   = 3;
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(7);

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   // one step's worth of octant data, handed from stepper to emitter
   typedef struct packed {
      logic [OFF_BITS-1:0]   off_x;
      logic [OFF_BITS-1:0]   off_y;
      logic [COORD_BITS-1:0] cen_x;
      logic [COORD_BITS-1:0] cen_y;
      logic [COLOR_BITS-1:0] color;
      logic                  done;
   } job_type;

endpackage

[rtl/core/circ_if.sv]
// ----------------------------------------------------------------------------
// circ_req_if / circ_rsp_if
// Valid/ready channels for commands in and pixels out.
// ----------------------------------------------------------------------------
interface circ_req_if
   import circ_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   cmd_type               command;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [COORD_BITS-1:0] radius;
   logic [COLOR_BITS-1:0] color;

   modport source (output valid, command, center_x, center_y, radius, color,
                   input ready);
   modport sink   (input valid, command, center_x, center_y, radius, color,
                   output ready);
endinterface

interface circ_rsp_if
   import circ_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [PIX_BITS-1:0] pixel_x;
   logic signed [PIX_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0]      pixel_color;
   logic                       last_of_step;
   logic                       circle_done;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_of_step,
                   circle_done, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_of_step,
                   circle_done, output ready);
endinterface

[rtl/core/circ_stepper.sv]
// ----------------------------------------------------------------------------
// circ_stepper
// Holds the circle state and applies the Andres update on every step beat of an active circle.
// ----------------------------------------------------------------------------
module circ_stepper
   import circ_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat,
   input  cmd_type               command,
   input  logic [COORD_BITS-1:0] center_x,
   input  logic [COORD_BITS-1:0] center_y,
   input  logic [COORD_BITS-1:0] radius,
   input  logic [COLOR_BITS-1:0] color,
   output logic                  job_load,
   output job_type               job
);

   logic [OFF_BITS-1:0]        off_x_ff, off_x_in;
   logic signed [OFF_BITS-1:0] off_y_ff, off_y_in;
   logic signed [DEC_BITS-1:0] dec_ff, dec_in;
   logic [COORD_BITS-1:0]      rad_ff, rad_in;
   logic [COORD_BITS-1:0]      cen_x_ff, cen_x_in;
   logic [COORD_BITS-1:0]      cen_y_ff, cen_y_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic                       active_ff, active_in;

   logic signed [CALC_BITS-1:0] x_c, y_c, d_c, r_c, x_n, y_n, d_n;
   logic                        done;

   assign x_c = signed'(CALC_BITS'(off_x_ff));
   assign y_c = CALC_BITS'(off_y_ff);
   assign d_c = CALC_BITS'(dec_ff);
   assign r_c = signed'(CALC_BITS'(rad_ff));

   always_comb begin
      priority if (d_c >= (x_c <<< 1)) begin
         d_n = d_c - (x_c <<< 1) - CALC_BITS'(1);
         x_n = x_c + CALC_BITS'(1);
         y_n = y_c;
      end else if (d_c < ((r_c - y_c) <<< 1)) begin
         d_n = d_c + (y_c <<< 1) - CALC_BITS'(1);
         x_n = x_c;
         y_n = y_c - CALC_BITS'(1);
      end else begin
         d_n = d_c + ((y_c - x_c - CALC_BITS'(1)) <<< 1);
         x_n = x_c + CALC_BITS'(1);
         y_n = y_c - CALC_BITS'(1);
      end
   end

   assign done     = y_n < x_n;
   assign job_load = beat && (command == CMD_STEP) && active_ff;

   // pixels use the offsets from before the update
   assign job.off_x = off_x_ff;
   assign job.off_y = off_y_ff;
   assign job.cen_x = cen_x_ff;
   assign job.cen_y = cen_y_ff;
   assign job.color = color_ff;
   assign job.done  = done;

   always_comb begin
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      dec_in    = dec_ff;
      rad_in    = rad_ff;
      cen_x_in  = cen_x_ff;
      cen_y_in  = cen_y_ff;
      color_in  = color_ff;
      active_in = active_ff;
      if (beat && (command == CMD_START)) begin
         off_x_in  = '0;
         off_y_in  = signed'(OFF_BITS'(radius));
         dec_in    = signed'(DEC_BITS'(radius)) - DEC_BITS'(1);
         rad_in    = radius;
         cen_x_in  = center_x;
         cen_y_in  = center_y;
         color_in  = color;
         active_in = 1'b1;
      end else if (job_load) begin
         off_x_in  = OFF_BITS'(x_n);
         off_y_in  = OFF_BITS'(y_n);
         dec_in    = DEC_BITS'(d_n);
         active_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         dec_ff    <= '0;
         rad_ff    <= '0;
         cen_x_ff  <= '0;
         cen_y_ff  <= '0;
         color_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         off_x_ff  <= off_x_in;
         off_y_ff  <= off_y_in;
         dec_ff    <= dec_in;
         rad_ff    <= rad_in;
         cen_x_ff  <= cen_x_in;
         cen_y_ff  <= cen_y_in;
         color_ff  <= color_in;
         active_ff <= active_in;
      end
   end

endmodule

[rtl/core/circ_emitter.sv]
// ----------------------------------------------------------------------------
// circ_emitter
// Registers one step's job and sends its eight mirrored pixels, one per beat.
// ----------------------------------------------------------------------------
module circ_emitter
   import circ_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_load,
   input  job_type    job,
   output logic       free,
   circ_rsp_if.source rsp_ch
);

   logic                busy_ff, busy_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   job_type             job_ff, job_in;

   logic                       last, taken;
   logic [OFF_BITS-1:0]        a_off, b_off;
   logic signed [PIX_BITS-1:0] cx_c, cy_c, a_c, b_c;

   assign last  = idx_ff == IDX_LAST;
   assign taken = busy_ff && rsp_ch.ready;
   // free now, or the final pixel leaves at this edge
   assign free  = !busy_ff || (taken && last);

   // bit 0 swaps x/y, bit 1 mirrors the column, bit 2 mirrors the row
   assign a_off = idx_ff[0] ? job_ff.off_y : job_ff.off_x;
   assign b_off = idx_ff[0] ? job_ff.off_x : job_ff.off_y;
   assign cx_c  = signed'(PIX_BITS'(job_ff.cen_x));
   assign cy_c  = signed'(PIX_BITS'(job_ff.cen_y));
   assign a_c   = signed'(PIX_BITS'(a_off));
   assign b_c   = signed'(PIX_BITS'(b_off));

   assign rsp_ch.valid        = busy_ff;
   assign rsp_ch.pixel_x      = idx_ff[1] ? (cx_c - a_c) : (cx_c + a_c);
   assign rsp_ch.pixel_y      = idx_ff[2] ? (cy_c - b_c) : (cy_c + b_c);
   assign rsp_ch.pixel_color  = job_ff.color;
   assign rsp_ch.last_of_step = last;
   assign rsp_ch.circle_done  = last && job_ff.done;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      job_in  = job_ff;
      if (job_load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         job_in  = job;
      end else if (taken) begin
         busy_in = !last;
         idx_in  = idx_ff + IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

[rtl/core/circle_outline_generator_core.sv]
// ----------------------------------------------------------------------------
// circle_outline_generator_core
// Andres circle rasterizer: start beats load a circle, step beats on an active circle
// emit the eight octant pixels of the current offset and advance it.
//
//   channel  dir  beat moves
//   req_ch   in   command, center_x, center_y, radius, color
//   rsp_ch   out  pixel_x, pixel_y, pixel_color, last_of_step, circle_done
//
// on a step on an active circle the emitter sends one pixel per beat and takes
// the next command on the cycle its eighth pixel leaves.
// start beats and idle steps emit nothing.
// reset is synchronous and clears the circle state and the emitter.
// a stall on rsp_ch holds the current pixel and blocks req_ch.
// ----------------------------------------------------------------------------
module circle_outline_generator_core
   import circ_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   circ_req_if.sink   req_ch,
   circ_rsp_if.source rsp_ch
);

   logic    free;
   logic    beat;
   logic    job_load;
   job_type job;

   assign req_ch.ready = free;
   assign beat         = req_ch.valid && free;

   circ_stepper u_stepper (
      .clock    (clock),
      .reset    (reset),
      .beat     (beat),
      .command  (req_ch.command),
      .center_x (req_ch.center_x),
      .center_y (req_ch.center_y),
      .radius   (req_ch.radius),
      .color    (req_ch.color),
      .job_load (job_load),
      .job      (job)
   );

   circ_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .job_load (job_load),
      .job      (job),
      .free     (free),
      .rsp_ch   (rsp_ch)
   );

endmodule
